FILE: src/hmm_forward_likelihood_core_macros.svh
// ----------------------------------------------------------------------------
// hmm_forward_likelihood_core_macros.svh
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef HMM_FORWARD_LIKELIHOOD_CORE_MACROS_SVH
`define HMM_FORWARD_LIKELIHOOD_CORE_MACROS_SVH

// same-cycle implication, reset masks the check
`define HFL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hfl assertion failed");

// next-cycle implication, reset masks the check
`define HFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hfl assertion failed");

`endif

FILE: src/hfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfl_pkg
// Constants, request codes and the log table of the forward-pass core.
// ----------------------------------------------------------------------------
package hfl_pkg;

    localparam int MAX_STATES  = 8;
    localparam int MAX_SYMBOLS = 16;
    localparam int PROB_BITS   = 16;

    localparam int STATE_BITS  = 3;   // log2(MAX_STATES)
    localparam int SYMBOL_BITS = 4;   // log2(MAX_SYMBOLS)

    // widths of the datapath at these table sizes
    localparam int MAC_BITS  = 35;    // sum of MAX_STATES Q0.32 products
    localparam int T_BITS    = 19;    // MAC result after the Q0.16 rescale
    localparam int RAW_BITS  = 35;    // T times emission
    localparam int SUM_BITS  = 38;    // sum of MAX_STATES raw values
    localparam int EXP_BITS  = 6;     // index of leading one of the sum
    localparam int DELTA_BITS = 34;

    // request codes
    localparam logic [1:0] OP_WR_TRANS = 2'd0;
    localparam logic [1:0] OP_WR_EMIT  = 2'd1;
    localparam logic [1:0] OP_WR_INIT  = 2'd2;
    localparam logic [1:0] OP_OBSERVE  = 2'd3;

    // register indexes
    localparam logic REG_NUM_STATES  = 1'b0;
    localparam logic REG_NUM_SYMBOLS = 1'b1;

    localparam logic [15:0] LN2_Q16 = 16'd45426;
    // 2*PROB_BITS times ln 2 in Q16.16
    localparam logic signed [DELTA_BITS-1:0] LN_OFFSET = 34'sd1453632;
    // -ln(1e11) in Q16.16
    localparam logic signed [DELTA_BITS-1:0] ZERO_SUM_PENALTY = -34'sd1659924;

    // ln(1 + k/16) in Q16.16
    function automatic logic [15:0] ln_tab(input logic [4:0] k);
        logic [15:0] v;
        case (k)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3973;
            5'd2:    v = 16'd7719;
            5'd3:    v = 16'd11262;
            5'd4:    v = 16'd14624;
            5'd5:    v = 16'd17821;
            5'd6:    v = 16'd20870;
            5'd7:    v = 16'd23783;
            5'd8:    v = 16'd26573;
            5'd9:    v = 16'd29248;
            5'd10:   v = 16'd31818;
            5'd11:   v = 16'd34292;
            5'd12:   v = 16'd36675;
            5'd13:   v = 16'd38975;
            5'd14:   v = 16'd41196;
            5'd15:   v = 16'd43345;
            5'd16:   v = 16'd45426;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/hmm_forward_likelihood_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmm_forward_likelihood_core
// Scaled HMM forward pass with a running Q16.16 log-likelihood.
// ----------------------------------------------------------------------------
// Input stream (s_*): s_tuser carries the request code (write transition,
// write emission, write initial, observe); s_tdata carries row, col, prob and
// symbol; s_tlast marks the last observation of a sequence. Write requests
// give no result. An observe request gives one result on the output stream
// (m_*): m_tdata = log-likelihood, m_tuser = underflow, m_tlast = end of
// sequence.
// An observe with n states in use: a first step multiplies init by emission
// per state; a later step first sums alpha[j]*trans[j][i] over the n states.
// Then every state is divided by the sum (8 states, one bit per cycle on the
// shared subtractor) and the log shifts the sum up to its leading one.
// One shared 19x16 multiplier does all products.
// s_tready is low while an observe is at work. A result waits in the output
// register while the receiver stalls; the block still takes writes, and the
// next observe only stalls at its final step until the register is free.
// Reset clears alpha, the accumulator and the underflow flag, and starts a
// new sequence; the tables hold nothing until written. APB port: register 0
// num_states_used at 0x0, register 1 num_symbols_used at 0x4.
// ----------------------------------------------------------------------------
module hmm_forward_likelihood_core
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // row[2:0], col[6:3], prob[22:7], symbol[26:23]
    input  logic [1:0]  s_tuser,    // op[1:0]
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // log_likelihood[31:0]
    output logic        m_tuser,    // underflow[0]
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SB = hfl_pkg::STATE_BITS;
    localparam int YB = hfl_pkg::SYMBOL_BITS;
    localparam int PB = hfl_pkg::PROB_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_STATE_SEL, ST_MAC_RD, ST_MAC_ACC, ST_EMIT_RD, ST_EMIT_MUL,
        ST_DIV_INIT, ST_DIV_STEP, ST_NORM, ST_LOG_FRAC, ST_LOG_EXP, ST_FINISH
    } state_t;

    // input fields
    logic [SB-1:0] in_row;
    logic [YB-1:0] in_col;
    logic [PB-1:0] in_prob;
    logic [YB-1:0] in_symbol;
    logic [1:0]    in_op;
    logic          in_acc;

    assign in_row    = s_tdata[2:0];
    assign in_col    = s_tdata[6:3];
    assign in_prob   = s_tdata[22:7];
    assign in_symbol = s_tdata[26:23];
    assign in_op     = s_tuser;

    // configuration registers
    logic [3:0] num_states_reg;
    logic [4:0] num_symbols_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == hfl_pkg::REG_NUM_SYMBOLS) ? {27'd0, num_symbols_reg}
                                                           : {28'd0, num_states_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg  <= 4'd5;
            num_symbols_reg <= 5'd9;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == hfl_pkg::REG_NUM_STATES)
                num_states_reg <= pwdata[3:0];
            else
                num_symbols_reg <= pwdata[4:0];
        end
    end

    // effective counts: zero acts as one, large values clamp
    logic [3:0] n_eff;
    logic [4:0] m_eff;
    always_comb
    begin
        if (num_states_reg == 4'd0)
            n_eff = 4'd1;
        else if (num_states_reg > 4'(hfl_pkg::MAX_STATES))
            n_eff = 4'(hfl_pkg::MAX_STATES);
        else
            n_eff = num_states_reg;
        if (num_symbols_reg == 5'd0)
            m_eff = 5'd1;
        else if (num_symbols_reg > 5'(hfl_pkg::MAX_SYMBOLS))
            m_eff = 5'(hfl_pkg::MAX_SYMBOLS);
        else
            m_eff = num_symbols_reg;
    end

    // sequencer registers
    state_t state_reg;
    logic [SB-1:0] i_reg;
    logic [SB-1:0] j_reg;
    logic [3:0]    bit_cnt_reg;
    logic [YB-1:0] sym_reg;
    logic          last_reg;
    logic          seq_start_reg;
    logic          underflow_seen_reg;
    logic signed [31:0] log_acc_reg;

    logic [hfl_pkg::MAC_BITS-1:0]   mac_reg;
    logic [hfl_pkg::T_BITS-1:0]     t_reg;
    logic [hfl_pkg::SUM_BITS-1:0]   sum_reg;
    logic [hfl_pkg::SUM_BITS-1:0]   rem_reg;
    logic [PB-1:0]                  quo_reg;
    logic [hfl_pkg::SUM_BITS-1:0]   norm_reg;
    logic [hfl_pkg::EXP_BITS-1:0]   exp_reg;
    logic [15:0]                    lm_reg;
    logic signed [hfl_pkg::DELTA_BITS-1:0] delta_reg;

    logic [PB-1:0] alpha_reg [hfl_pkg::MAX_STATES];
    logic [hfl_pkg::RAW_BITS-1:0] raw_reg [hfl_pkg::MAX_STATES];

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        m_tlast_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;

    // table memories: written on accepted write requests, read data registered
    logic [PB-1:0] trans_mem [hfl_pkg::MAX_STATES * hfl_pkg::MAX_STATES];
    logic [PB-1:0] emit_mem  [hfl_pkg::MAX_STATES * hfl_pkg::MAX_SYMBOLS];
    logic [PB-1:0] init_mem  [hfl_pkg::MAX_STATES];
    logic [PB-1:0] trans_rd_reg;
    logic [PB-1:0] emit_rd_reg;
    logic [PB-1:0] init_rd_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc && in_op == hfl_pkg::OP_WR_TRANS && in_col[YB-1] == 1'b0)
            trans_mem[{in_row, in_col[SB-1:0]}] <= in_prob;
        trans_rd_reg <= trans_mem[{j_reg, i_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && in_op == hfl_pkg::OP_WR_EMIT)
            emit_mem[{in_row, in_col}] <= in_prob;
        emit_rd_reg <= emit_mem[{i_reg, sym_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && in_op == hfl_pkg::OP_WR_INIT && in_col[YB-1] == 1'b0)
            init_mem[in_col[SB-1:0]] <= in_prob;
        init_rd_reg <= init_mem[i_reg];
    end

    // shared multiplier and its operand select
    logic [hfl_pkg::T_BITS-1:0] mul_a;
    logic [15:0]                mul_b;
    logic [hfl_pkg::RAW_BITS-1:0] mul_p;
    logic [3:0]  log_idx;
    logic [15:0] log_lo;
    logic [15:0] log_hi;

    assign log_idx = norm_reg[36:33];
    assign log_lo  = hfl_pkg::ln_tab({1'b0, log_idx});
    assign log_hi  = hfl_pkg::ln_tab(5'({1'b0, log_idx}) + 5'd1);

    always_comb
    begin
        case (state_reg)
            ST_MAC_ACC:
            begin
                mul_a = hfl_pkg::T_BITS'(alpha_reg[j_reg]);
                mul_b = trans_rd_reg;
            end
            ST_EMIT_MUL:
            begin
                mul_a = seq_start_reg ? hfl_pkg::T_BITS'(init_rd_reg) : t_reg;
                mul_b = ({1'b0, sym_reg} < m_eff) ? emit_rd_reg : 16'd0;
            end
            ST_LOG_FRAC:
            begin
                mul_a = hfl_pkg::T_BITS'(log_hi - log_lo);
                mul_b = norm_reg[32:17];
            end
            ST_LOG_EXP:
            begin
                mul_a = hfl_pkg::T_BITS'(exp_reg);
                mul_b = hfl_pkg::LN2_Q16;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = hfl_pkg::RAW_BITS'(mul_a) * hfl_pkg::RAW_BITS'(mul_b);

    // helpers
    logic [hfl_pkg::MAC_BITS-1:0] mac_next;
    logic [hfl_pkg::SUM_BITS:0]   rem_shift;
    logic                         rem_ge;
    logic [hfl_pkg::SUM_BITS-1:0] raw_cur;
    logic signed [hfl_pkg::DELTA_BITS-1:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic               out_free;

    assign mac_next  = mac_reg + mul_p;
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, sum_reg};
    assign raw_cur   = hfl_pkg::SUM_BITS'(raw_reg[i_reg]);
    assign acc_sum   = hfl_pkg::DELTA_BITS'(log_acc_reg) + delta_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        if (acc_sum > 34'sd2147483647)
            acc_sat = 32'h7FFF_FFFF;
        else if (acc_sum < -34'sd2147483648)
            acc_sat = 32'h8000_0000;
        else
            acc_sat = acc_sum[31:0];
    end

    // raw values are payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_STATE_SEL && {1'b0, i_reg} >= n_eff)
            raw_reg[i_reg] <= '0;
        else if (state_reg == ST_EMIT_MUL)
            raw_reg[i_reg] <= mul_p;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            i_reg              <= '0;
            j_reg              <= '0;
            bit_cnt_reg        <= '0;
            sym_reg            <= '0;
            last_reg           <= 1'b0;
            seq_start_reg      <= 1'b1;
            underflow_seen_reg <= 1'b0;
            log_acc_reg        <= '0;
            mac_reg            <= '0;
            t_reg              <= '0;
            sum_reg            <= '0;
            rem_reg            <= '0;
            quo_reg            <= '0;
            norm_reg           <= '0;
            exp_reg            <= '0;
            lm_reg             <= '0;
            delta_reg          <= '0;
            m_tvalid_reg       <= 1'b0;
            m_tdata_reg        <= '0;
            m_tuser_reg        <= 1'b0;
            m_tlast_reg        <= 1'b0;
            for (int k = 0; k < hfl_pkg::MAX_STATES; k++)
                alpha_reg[k] <= '0;
        end
        else
        begin
            // result taken; a new one in ST_FINISH sets valid itself
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && in_op == hfl_pkg::OP_OBSERVE)
                    begin
                        sym_reg   <= in_symbol;
                        last_reg  <= s_tlast;
                        i_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_STATE_SEL;
                    end
                end

                // pick the work for state i
                ST_STATE_SEL:
                begin
                    if ({1'b0, i_reg} >= n_eff)
                    begin
                        if (i_reg == SB'(hfl_pkg::MAX_STATES - 1))
                        begin
                            i_reg     <= '0;
                            state_reg <= ST_DIV_INIT;
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                    else if (seq_start_reg)
                        state_reg <= ST_EMIT_RD;
                    else
                    begin
                        j_reg     <= '0;
                        mac_reg   <= '0;
                        state_reg <= ST_MAC_RD;
                    end
                end

                ST_MAC_RD:
                    state_reg <= ST_MAC_ACC;

                // alpha[j] * trans[j][i]
                ST_MAC_ACC:
                begin
                    mac_reg <= mac_next;
                    if ({1'b0, j_reg} == n_eff - 4'd1)
                    begin
                        t_reg     <= mac_next[hfl_pkg::MAC_BITS-1:PB];
                        state_reg <= ST_EMIT_RD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_MAC_RD;
                    end
                end

                ST_EMIT_RD:
                    state_reg <= ST_EMIT_MUL;

                // raw[i] and running sum
                ST_EMIT_MUL:
                begin
                    sum_reg <= sum_reg + hfl_pkg::SUM_BITS'(mul_p);
                    if (i_reg == SB'(hfl_pkg::MAX_STATES - 1))
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_DIV_INIT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_STATE_SEL;
                    end
                end

                // normalise state i, or settle it at once
                ST_DIV_INIT:
                begin
                    if (sum_reg == '0 || raw_cur >= sum_reg)
                    begin
                        alpha_reg[i_reg] <= (sum_reg == '0) ? '0 : '1;
                        if (i_reg == SB'(hfl_pkg::MAX_STATES - 1))
                        begin
                            if (sum_reg == '0)
                            begin
                                delta_reg          <= hfl_pkg::ZERO_SUM_PENALTY;
                                underflow_seen_reg <= 1'b1;
                                state_reg          <= ST_FINISH;
                            end
                            else
                            begin
                                norm_reg  <= sum_reg;
                                exp_reg   <= hfl_pkg::EXP_BITS'(hfl_pkg::SUM_BITS - 1);
                                state_reg <= ST_NORM;
                            end
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        rem_reg     <= raw_cur;
                        quo_reg     <= '0;
                        bit_cnt_reg <= '0;
                        state_reg   <= ST_DIV_STEP;
                    end
                end

                // restoring division, one quotient bit a cycle
                ST_DIV_STEP:
                begin
                    rem_reg <= rem_ge ? hfl_pkg::SUM_BITS'(rem_shift - {1'b0, sum_reg})
                                      : rem_shift[hfl_pkg::SUM_BITS-1:0];
                    quo_reg     <= {quo_reg[PB-2:0], rem_ge};
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == 4'(PB - 1))
                    begin
                        alpha_reg[i_reg] <= {quo_reg[PB-2:0], rem_ge};
                        if (i_reg == SB'(hfl_pkg::MAX_STATES - 1))
                        begin
                            norm_reg  <= sum_reg;
                            exp_reg   <= hfl_pkg::EXP_BITS'(hfl_pkg::SUM_BITS - 1);
                            state_reg <= ST_NORM;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_DIV_INIT;
                        end
                    end
                end

                // find the leading one, one place a cycle
                ST_NORM:
                begin
                    if (norm_reg[hfl_pkg::SUM_BITS-1])
                        state_reg <= ST_LOG_FRAC;
                    else
                    begin
                        norm_reg <= {norm_reg[hfl_pkg::SUM_BITS-2:0], 1'b0};
                        exp_reg  <= exp_reg - 1'b1;
                    end
                end

                // table value plus interpolation
                ST_LOG_FRAC:
                begin
                    lm_reg    <= log_lo + mul_p[31:16];
                    state_reg <= ST_LOG_EXP;
                end

                // exponent times ln 2, less the Q0.32 offset
                ST_LOG_EXP:
                begin
                    delta_reg <= hfl_pkg::DELTA_BITS'(mul_p) - hfl_pkg::LN_OFFSET
                                 + hfl_pkg::DELTA_BITS'(lm_reg);
                    state_reg <= ST_FINISH;
                end

                // accumulate and hand over the result
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= acc_sat;
                        m_tuser_reg  <= underflow_seen_reg;
                        m_tlast_reg  <= last_reg;
                        if (last_reg)
                        begin
                            log_acc_reg        <= '0;
                            underflow_seen_reg <= 1'b0;
                            seq_start_reg      <= 1'b1;
                        end
                        else
                        begin
                            log_acc_reg   <= acc_sat;
                            seq_start_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: src/hfl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfl_checker
// Port-level checks of the forward-pass core, bound to the top level.
// ----------------------------------------------------------------------------
`include "hmm_forward_likelihood_core_macros.svh"

module hfl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result holds
    `HFL_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // an accepted observe keeps the input closed while it works
    `HFL_ASSERT_NEXT(a_obs_busy, clk, rst_n, s_tvalid && s_tready && s_tuser == hfl_pkg::OP_OBSERVE, !s_tready)

    // with the core idle no result appears out of nothing
    `HFL_ASSERT_NEXT(a_no_spurious, clk, rst_n, s_tready && !m_tvalid, !m_tvalid)

    // a result only turns up once the input has reopened
    `HFL_ASSERT_SAME(a_result_idle, clk, rst_n, $rose(m_tvalid), s_tready)

endmodule

bind hmm_forward_likelihood_core hfl_checker u_hfl_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
